FILE: src/assert_macros.svh
// Assertion macros used by the checker in gcs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/gcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
package gcs_pkg;

   localparam int MAX_STOPS = 8;
   localparam int FRAC_BITS = 16;
   localparam int STOP_AW   = $clog2(MAX_STOPS);
   localparam int CNT_W     = 4;
   localparam int OFF_W     = FRAC_BITS + 1;
   localparam int POS_W     = 24;
   localparam int COLOR_W   = 32;
   localparam int ENTRY_W   = OFF_W + COLOR_W;
   localparam int DIV_CNT_W = $clog2(OFF_W + 1);

   localparam logic [OFF_W-1:0]   ONE_FX      = OFF_W'(1) << FRAC_BITS;
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'h0000_00FF;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic CSR_SPREAD_MODE = 1'b0;
   localparam logic CSR_STOP_COUNT  = 1'b1;

   localparam logic [1:0] SPREAD_PAD     = 2'd0;
   localparam logic [1:0] SPREAD_REPEAT  = 2'd1;
   localparam logic [1:0] SPREAD_REFLECT = 2'd2;

   typedef struct packed {
      logic                 is_sample;
      logic [STOP_AW-1:0]   idx;
      logic [OFF_W-1:0]     offset;
      logic [COLOR_W-1:0]   color;
      logic [OFF_W-1:0]     t;
   } qitem_type;

   typedef struct packed {
      logic      push;
      qitem_type item;
   } push_type;

   typedef struct packed {
      logic      empty;
      qitem_type head;
   } head_type;

   typedef struct packed {
      logic                 we;
      logic [STOP_AW-1:0]   waddr;
      logic [ENTRY_W-1:0]   wdata;
      logic [STOP_AW-1:0]   raddr;
   } ram_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_FIRST,
      ST_SCAN,
      ST_DIV,
      ST_MULT,
      ST_SUM,
      ST_FINISH
   } back_state_type;

endpackage

FILE: src/gcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler channel interfaces
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface gcs_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [2:0]         stop_index;
   logic [16:0]        stop_offset;
   logic [7:0]         stop_red;
   logic [7:0]         stop_green;
   logic [7:0]         stop_blue;
   logic [7:0]         stop_alpha;
   logic signed [23:0] position;
   modport source (output valid, func, stop_index, stop_offset, stop_red, stop_green,
                   stop_blue, stop_alpha, position, input ready);
   modport sink (input valid, func, stop_index, stop_offset, stop_red, stop_green,
                 stop_blue, stop_alpha, position, output ready);
endinterface

interface gcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface gcs_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [3:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/gradient_color_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler core
// The back end stores a stop write from its idle state. A sample with no
// stops answers black; otherwise it reads the last and first stops and, for
// t between them, scans the segments, divides, multiplies and sums: the scan reads
// one table entry per cycle through a single RAM read port, and the segment
// division is bit-serial, one quotient bit per cycle. Register writes are
// taken every cycle.
// ----------------------------------------------------------------------------
module gradient_color_sampler_core (
   input  logic       clock,
   input  logic       reset,
   gcs_req_if.sink    req_bus,
   gcs_rsp_if.source  rsp_bus,
   gcs_csr_if.sink    csr_bus
);

   logic [1:0]                  spread_mode_ff, spread_mode_in;
   logic [gcs_pkg::CNT_W-1:0]   stop_count_ff, stop_count_in;
   logic [gcs_pkg::CNT_W-1:0]   stop_n;
   gcs_pkg::push_type           push;
   gcs_pkg::head_type           head;
   gcs_pkg::ram_req_type        ram_req;
   logic                        queue_full;
   logic                        pop;
   logic [gcs_pkg::ENTRY_W-1:0] ram_rdata;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      spread_mode_in = spread_mode_ff;
      stop_count_in  = stop_count_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            gcs_pkg::CSR_SPREAD_MODE: spread_mode_in = csr_bus.data[1:0];
            gcs_pkg::CSR_STOP_COUNT:  stop_count_in  = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_mode_ff <= gcs_pkg::SPREAD_PAD;
         stop_count_ff  <= '0;
      end else begin
         spread_mode_ff <= spread_mode_in;
         stop_count_ff  <= stop_count_in;
      end
   end

   assign stop_n = (stop_count_ff > gcs_pkg::CNT_W'(gcs_pkg::MAX_STOPS))
                   ? gcs_pkg::CNT_W'(gcs_pkg::MAX_STOPS) : stop_count_ff;

   gcs_front u_front (
      .req_bus     (req_bus),
      .spread_mode (spread_mode_ff),
      .queue_full  (queue_full),
      .push_out    (push)
   );

   gcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop      (pop),
      .full     (queue_full),
      .head_out (head)
   );

   gcs_ram #(
      .WIDTH (gcs_pkg::ENTRY_W),
      .DEPTH (gcs_pkg::MAX_STOPS)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   gcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_in   (head),
      .stop_n    (stop_n),
      .pop       (pop),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: src/gcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/gcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler front end
// Accept transactions, fold sample positions by spread mode, queue them.
// ----------------------------------------------------------------------------
module gcs_front (
   gcs_req_if.sink            req_bus,
   input  logic [1:0]         spread_mode,
   input  logic               queue_full,
   output gcs_pkg::push_type  push_out
);

   logic signed [23:0]          pos;
   logic [gcs_pkg::OFF_W-1:0]   frac;
   logic [gcs_pkg::OFF_W-1:0]   t_fold;

   assign pos  = req_bus.position;
   assign frac = {1'b0, pos[gcs_pkg::FRAC_BITS-1:0]};

   always_comb begin
      case (spread_mode)
         gcs_pkg::SPREAD_REPEAT: t_fold = frac;
         gcs_pkg::SPREAD_REFLECT: begin
            t_fold = pos[gcs_pkg::FRAC_BITS] ? (gcs_pkg::ONE_FX - frac) : frac;
         end
         default: begin
            if (pos < 0) begin
               t_fold = '0;
            end else if (pos > $signed({7'd0, gcs_pkg::ONE_FX})) begin
               t_fold = gcs_pkg::ONE_FX;
            end else begin
               t_fold = pos[gcs_pkg::OFF_W-1:0];
            end
         end
      endcase
   end

   assign req_bus.ready = !queue_full;

   always_comb begin
      push_out.push           = req_bus.valid && !queue_full;
      push_out.item.is_sample = (req_bus.func == gcs_pkg::FUNC_SAMPLE);
      push_out.item.idx       = req_bus.stop_index;
      push_out.item.offset    = req_bus.stop_offset;
      push_out.item.color     = {req_bus.stop_red, req_bus.stop_green,
                                 req_bus.stop_blue, req_bus.stop_alpha};
      push_out.item.t         = t_fold;
   end

endmodule

FILE: src/gcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module gcs_queue (
   input  logic              clock,
   input  logic              reset,
   input  gcs_pkg::push_type push_in,
   input  logic              pop,
   output logic              full,
   output gcs_pkg::head_type head_out
);

   gcs_pkg::qitem_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full   = (count_ff == 2'd2);
   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_in.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push_in.push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.item;
      end
   end

   assign head_out.empty = (count_ff == 2'd0);
   assign head_out.head  = entry_ff[rd_ptr_ff];

endmodule

FILE: src/gcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler back end
// Store stops, scan segments, divide, blend and hold the response.
// ----------------------------------------------------------------------------
module gcs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  gcs_pkg::head_type              head_in,
   input  logic [gcs_pkg::CNT_W-1:0]      stop_n,
   output logic                           pop,
   output gcs_pkg::ram_req_type           ram_req,
   input  logic [gcs_pkg::ENTRY_W-1:0]    ram_rdata,
   gcs_rsp_if.source                      rsp_bus
);

   localparam int OW = gcs_pkg::OFF_W;
   localparam int CW = gcs_pkg::COLOR_W;
   localparam int PW = OW + 10;

   gcs_pkg::back_state_type state_ff, state_in;

   logic [OW-1:0]                t_ff, t_in;
   logic [OW-1:0]                lo_ff, lo_in;
   logic [CW-1:0]                ca_ff, ca_in;
   logic [CW-1:0]                cb_ff, cb_in;
   logic [OW-1:0]                last_off_ff, last_off_in;
   logic [CW-1:0]                last_col_ff, last_col_in;
   logic [gcs_pkg::STOP_AW-1:0]  idx_ff, idx_in;
   logic [OW-1:0]                len_ff, len_in;
   logic [OW:0]                  rem_ff, rem_in;
   logic [OW-1:0]                q_ff, q_in;
   logic [gcs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]                color_ff, color_in;
   logic signed [PW-1:0]         prod_ff [4];
   logic signed [PW-1:0]         prod_in [4];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                rsp_color_ff;
   logic                         out_free;
   logic                         load_out;

   logic [OW-1:0]                rd_off;
   logic [CW-1:0]                rd_col;
   logic [gcs_pkg::CNT_W-1:0]    n_last;
   logic                         ge;
   logic [OW:0]                  rem_sub;
   logic signed [8:0]            diff [4];
   logic signed [PW-1:0]         sum [4];

   assign rd_off   = ram_rdata[gcs_pkg::ENTRY_W-1 -: OW];
   assign rd_col   = ram_rdata[CW-1:0];
   assign n_last   = stop_n - 4'd1;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign ge       = (rem_ff >= {1'b0, len_ff});
   assign rem_sub  = ge ? (rem_ff - {1'b0, len_ff}) : rem_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         diff[k] = $signed({1'b0, cb_ff[8*k +: 8]}) - $signed({1'b0, ca_ff[8*k +: 8]});
         prod_in[k] = diff[k] * $signed({1'b0, q_ff});
         sum[k] = $signed({{(PW-24){1'b0}}, ca_ff[8*k +: 8], 16'd0}) + prod_ff[k];
      end
   end

   always_comb begin
      state_in    = state_ff;
      t_in        = t_ff;
      lo_in       = lo_ff;
      ca_in       = ca_ff;
      cb_in       = cb_ff;
      last_off_in = last_off_ff;
      last_col_in = last_col_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      cnt_in      = cnt_ff;
      color_in    = color_ff;
      pop         = 1'b0;
      load_out    = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.waddr = head_in.head.idx;
      ram_req.wdata = {head_in.head.offset, head_in.head.color};
      ram_req.raddr = '0;
      case (state_ff)
         gcs_pkg::ST_IDLE: begin
            if (!head_in.empty) begin
               pop = 1'b1;
               if (!head_in.head.is_sample) begin
                  ram_req.we = 1'b1;
               end else begin
                  t_in = head_in.head.t;
                  if (stop_n == '0) begin
                     color_in = gcs_pkg::COLOR_BLACK;
                     state_in = gcs_pkg::ST_FINISH;
                  end else begin
                     ram_req.raddr = n_last[gcs_pkg::STOP_AW-1:0];
                     state_in = gcs_pkg::ST_LAST;
                  end
               end
            end
         end
         gcs_pkg::ST_LAST: begin
            last_off_in = rd_off;
            last_col_in = rd_col;
            ram_req.raddr = '0;
            state_in = gcs_pkg::ST_FIRST;
         end
         gcs_pkg::ST_FIRST: begin
            if (stop_n == 4'd1 || t_ff <= rd_off) begin
               color_in = rd_col;
               state_in = gcs_pkg::ST_FINISH;
            end else if (t_ff >= last_off_ff) begin
               color_in = last_col_ff;
               state_in = gcs_pkg::ST_FINISH;
            end else begin
               lo_in  = rd_off;
               ca_in  = rd_col;
               idx_in = gcs_pkg::STOP_AW'(1);
               ram_req.raddr = gcs_pkg::STOP_AW'(1);
               state_in = gcs_pkg::ST_SCAN;
            end
         end
         gcs_pkg::ST_SCAN: begin
            if (t_ff >= lo_ff && t_ff <= rd_off) begin
               if (rd_off == lo_ff) begin
                  color_in = ca_ff;
                  state_in = gcs_pkg::ST_FINISH;
               end else begin
                  cb_in  = rd_col;
                  len_in = rd_off - lo_ff;
                  rem_in = {1'b0, t_ff - lo_ff};
                  q_in   = '0;
                  cnt_in = gcs_pkg::DIV_CNT_W'(OW);
                  state_in = gcs_pkg::ST_DIV;
               end
            end else if ({1'b0, idx_ff} == n_last) begin
               color_in = last_col_ff;
               state_in = gcs_pkg::ST_FINISH;
            end else begin
               lo_in  = rd_off;
               ca_in  = rd_col;
               idx_in = idx_ff + 1'b1;
               ram_req.raddr = idx_ff + 1'b1;
            end
         end
         gcs_pkg::ST_DIV: begin
            q_in   = {q_ff[OW-2:0], ge};
            rem_in = {rem_sub[OW-1:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == gcs_pkg::DIV_CNT_W'(1)) begin
               state_in = gcs_pkg::ST_MULT;
            end
         end
         gcs_pkg::ST_MULT: begin
            state_in = gcs_pkg::ST_SUM;
         end
         gcs_pkg::ST_SUM: begin
            for (int k = 0; k < 4; k++) begin
               color_in[8*k +: 8] = sum[k][23:16];
            end
            state_in = gcs_pkg::ST_FINISH;
         end
         gcs_pkg::ST_FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = gcs_pkg::ST_IDLE;
            end
         end
         default: state_in = gcs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      lo_ff       <= lo_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      last_off_ff <= last_off_in;
      last_col_ff <= last_col_in;
      idx_ff      <= idx_in;
      len_ff      <= len_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      color_ff    <= color_in;
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= prod_in[k];
      end
      if (load_out) begin
         rsp_color_ff <= color_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = rsp_color_ff[31:24];
   assign rsp_bus.out_green = rsp_color_ff[23:16];
   assign rsp_bus.out_blue  = rsp_color_ff[15:8];
   assign rsp_bus.out_alpha = rsp_color_ff[7:0];

endmodule

FILE: src/gcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha
);

   `CHK_NEXT(a_rsp_idle_after_reset, clock, reset, !rsp_valid, "response valid after reset")
   `CHK_NEXT(a_req_ready_after_reset, clock, reset, req_ready, "request not ready after reset")
   `CHK_NEXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_alpha), "stalled response changed")

endmodule

bind gradient_color_sampler_core gcs_checker u_gcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.out_red),
   .rsp_alpha (rsp_bus.out_alpha)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color sampler testbench
// Loads color stop tables, sweeps spread modes and stop counts, and samples
// positions through randomly throttled request and response channels. Each
// response is compared against a local fixed-point gradient predictor.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic               func;
      logic [2:0]         idx;
      logic [16:0]        offset;
      logic [7:0]         red, green, blue, alpha;
      logic signed [23:0] pos;
   } gradient_req_type;

   typedef struct {
      logic [7:0] red, green, blue, alpha;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcs_req_if req ();
   gcs_rsp_if rsp ();
   gcs_csr_if csr ();

   gradient_color_sampler_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   always #1 clock = ~clock;

   gradient_req_type pending_q[$];
   pixel_type        pixel_expected_q[$];
   gradient_req_type cur_req;
   longint           stop_offset_tab[gcs_pkg::MAX_STOPS];
   logic [31:0]      stop_color_tab[gcs_pkg::MAX_STOPS];
   logic [1:0]       spread_sel;
   logic [3:0]       stop_total;
   int               mismatches;
   int               cycles;
   int               burst_left;
   int               gap_left;
   int               stall_mode;
   bit               hold_sender;

   function automatic longint fold_pos(logic signed [23:0] pos);
      longint t;
      longint fr;
      t  = pos;
      fr = t & 65535;
      if (spread_sel == gcs_pkg::SPREAD_REPEAT) return fr;
      if (spread_sel == gcs_pkg::SPREAD_REFLECT) return t[16] ? 65536 - fr : fr;
      if (t < 0) return 0;
      if (t > 65536) return 65536;
      return t;
   endfunction

   function automatic logic [31:0] blend(logic [31:0] ca, logic [31:0] cb, longint loc);
      logic [31:0] res;
      longint      a, b, v;
      for (int s = 0; s < 4; s++) begin
         a = ca[s*8 +: 8];
         b = cb[s*8 +: 8];
         v = a * 65536 + (b - a) * loc;
         if (v < 0) v = 0;
         v = v / 65536;
         if (v > 255) v = 255;
         res[s*8 +: 8] = v[7:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] sample_color(logic signed [23:0] pos);
      longint t, lo, hi, len;
      int     n;
      t = fold_pos(pos);
      n = (stop_total > gcs_pkg::MAX_STOPS) ? gcs_pkg::MAX_STOPS : stop_total;
      if (n == 0) return gcs_pkg::COLOR_BLACK;
      if (n == 1) return stop_color_tab[0];
      if (t <= stop_offset_tab[0]) return stop_color_tab[0];
      if (t >= stop_offset_tab[n-1]) return stop_color_tab[n-1];
      for (int i = 0; i + 1 < n; i++) begin
         lo = stop_offset_tab[i];
         hi = stop_offset_tab[i+1];
         if (t >= lo && t <= hi) begin
            len = hi - lo;
            if (len <= 0) return stop_color_tab[i];
            return blend(stop_color_tab[i], stop_color_tab[i+1], ((t - lo) * 65536) / len);
         end
      end
      return stop_color_tab[n-1];
   endfunction

   task automatic apply_req(gradient_req_type r);
      logic [31:0] c;
      pixel_type   p;
      if (r.func == gcs_pkg::FUNC_WRITE) begin
         stop_offset_tab[r.idx] = r.offset;
         stop_color_tab[r.idx]  = {r.red, r.green, r.blue, r.alpha};
      end else begin
         c = sample_color(r.pos);
         p.red = c[31:24]; p.green = c[23:16]; p.blue = c[15:8]; p.alpha = c[7:0];
         pixel_expected_q.push_back(p);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid  <= 1'b0;
         burst_left <= 1;
         gap_left   <= 0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) apply_req(cur_req);
         if (gap_left > 0 || hold_sender || pending_q.size() == 0) begin
            req.valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            cur_req = pending_q.pop_front();
            req.valid      <= 1'b1;
            req.func       <= cur_req.func;
            req.stop_index <= cur_req.idx;
            req.stop_offset <= cur_req.offset;
            req.stop_red   <= cur_req.red;
            req.stop_green <= cur_req.green;
            req.stop_blue  <= cur_req.blue;
            req.stop_alpha <= cur_req.alpha;
            req.position   <= cur_req.pos;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type e;
      cycles <= cycles + 1;
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ((cycles % 16) < 5);
         endcase
         if (rsp.valid && rsp.ready) begin
            if (pixel_expected_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected pixel %h %h %h %h", rsp.out_red,
                                             rsp.out_green, rsp.out_blue, rsp.out_alpha);
            end else begin
               e = pixel_expected_q.pop_front();
               if (e.red !== rsp.out_red || e.green !== rsp.out_green ||
                   e.blue !== rsp.out_blue || e.alpha !== rsp.out_alpha) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("pixel mismatch exp %h %h %h %h got %h %h %h %h",
                              e.red, e.green, e.blue, e.alpha, rsp.out_red,
                              rsp.out_green, rsp.out_blue, rsp.out_alpha);
               end
            end
         end
      end
      if (cycles > 3000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic gradient_req_type rand_req(logic func);
      gradient_req_type r;
      r.func   = func;
      r.idx    = $urandom_range(0, 7);
      r.offset = $urandom_range(0, 65536);
      r.red    = $urandom; r.green = $urandom; r.blue = $urandom; r.alpha = $urandom;
      r.pos    = $urandom;
      return r;
   endfunction

   task automatic push_sample(logic signed [23:0] pos);
      gradient_req_type r;
      r = rand_req(gcs_pkg::FUNC_SAMPLE);
      r.pos = pos;
      pending_q.push_back(r);
   endtask

   task automatic push_stop(int idx, longint off);
      gradient_req_type r;
      r = rand_req(gcs_pkg::FUNC_WRITE);
      r.idx = idx;
      r.offset = off;
      pending_q.push_back(r);
   endtask

   // sorted tables with optional duplicates, ends pinned, or unsorted noise
   task automatic load_table(int kind);
      longint offs[8];
      for (int i = 0; i < 8; i++) offs[i] = $urandom_range(0, 65536);
      if (kind != 3) offs.sort();
      if (kind == 1) begin
         offs[0] = 0;
         offs[7] = 65536;
      end
      if (kind == 2) offs[$urandom_range(1, 7)] = offs[$urandom_range(0, 6)];
      if (kind == 2) offs.sort();
      for (int i = 0; i < 8; i++) push_stop(i, offs[i]);
   endtask

   function automatic logic signed [23:0] rand_pos();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $urandom_range(0, 6 * 65536) - 3 * 65536;
      if (sel < 8) return stop_offset_tab[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
      return $urandom;
   endfunction

   task automatic write_csr(logic idx, logic [3:0] d);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= d;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      if (idx == gcs_pkg::CSR_SPREAD_MODE) spread_sel = d[1:0];
      else stop_total = d;
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      hold_sender = 1'b0;
      while (pending_q.size() != 0 || req.valid) @(posedge clock);
      while (pixel_expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_mode(logic [3:0] sm, logic [3:0] cnt);
      write_csr(gcs_pkg::CSR_SPREAD_MODE, sm);
      write_csr(gcs_pkg::CSR_STOP_COUNT, cnt);
   endtask

   initial begin
      int total;
      req.valid = 1'b0; req.func = gcs_pkg::FUNC_WRITE; req.stop_index = '0;
      req.stop_offset = '0;
      req.stop_red = '0; req.stop_green = '0; req.stop_blue = '0; req.stop_alpha = '0;
      req.position = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = gcs_pkg::CSR_SPREAD_MODE; csr.data = '0;
      spread_sel = gcs_pkg::SPREAD_PAD; stop_total = 0;
      mismatches = 0; cycles = 0; stall_mode = 0; hold_sender = 1'b0;
      for (int i = 0; i < 8; i++) begin
         stop_offset_tab[i] = 0;
         stop_color_tab[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, full-scale positions, then fixed stop layout
      push_sample(24'sh7FFFFF);
      push_sample(24'sh800000);
      push_stop(0, 0);
      push_stop(1, 16384);
      push_stop(2, 16384);
      push_stop(3, 32768);
      push_stop(4, 40000);
      push_stop(5, 50000);
      push_stop(6, 60000);
      push_stop(7, 65536);
      push_sample(0);
      drain();
      set_mode(gcs_pkg::SPREAD_PAD, 1);
      push_sample(-1);
      push_sample(65536);
      drain();
      set_mode(gcs_pkg::SPREAD_PAD, 8);
      push_sample(-5);
      push_sample(0);
      push_sample(16384);
      push_sample(20000);
      push_sample(65536);
      push_sample(70000);
      push_sample(65535);
      drain();
      set_mode(gcs_pkg::SPREAD_REPEAT, 4'hF);
      push_sample(-30000);
      push_sample(3 * 65536 + 100);
      drain();
      set_mode(4'hE, 8);
      push_sample(65536 + 100);
      push_sample(-100);
      drain();
      set_mode(4'h3, 3);
      push_sample(-7);
      push_sample(45000);
      drain();
      total = 30;

      // random phases; the drain after each phase waits until all requests and responses are done
      while (total < 1950) begin
         set_mode($urandom_range(0, 15), ($urandom_range(0, 4) == 0) ?
                  $urandom_range(0, 15) : $urandom_range(2, 8));
         load_table(($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2));
         total += 8;
         for (int k = 0; k < 60; k++) begin
            if ($urandom_range(0, 19) == 0) pending_q.push_back(rand_req(gcs_pkg::FUNC_WRITE));
            else push_sample(rand_pos());
            total++;
         end
         drain();
      end

      if (mismatches == 0 && pixel_expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
